### hdl/upst_pkg.sv
// ----------------------------------------------------------------------------
// upst_pkg
// Shared types and constants of the micro-op stage pipeline timer.
// ----------------------------------------------------------------------------
`default_nettype none
package upst_pkg;

  localparam int unsigned NUM_STAGES = 5;
  localparam int unsigned DEF_DEPTH  = 8;
  localparam int unsigned TAG_W      = 16;
  localparam int unsigned DLY_W      = 8;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned CNT_W      = 7;   // holds a fill count up to 127
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned MAX_RET    = 8;
  localparam int unsigned RET_W      = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned WIDTH_W    = 4;

  // Buffer numbers along the chain.
  localparam logic [2:0] STG_ISSUE  = 3'd0;
  localparam logic [2:0] STG_DECODE = 3'd1;
  localparam logic [2:0] STG_READ   = 3'd2;
  localparam logic [2:0] STG_EXEC   = 3'd3;
  localparam logic [2:0] STG_WRITE  = 3'd4;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REJECT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RETIRE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_IDLE   = 2'd3;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEC_LAT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_READ_LAT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXEC_LAT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_LAT = 3'd4;

  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_RETIRE = 3'b010,
    ST_MOVE   = 3'b100
  } state_e;

  // Control of one buffer cell, applied each cycle.
  typedef struct packed {
    logic              push;      // append at the fill position
    logic              wr_en;     // compaction write at wr_addr
    logic [CNT_W-1:0]  wr_addr;
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] rdy;
    logic              fill_set;  // load the fill count
    logic [CNT_W-1:0]  fill_val;
  } cell_ctl_t;

endpackage
`default_nettype wire

### hdl/upst_cell.sv
// ----------------------------------------------------------------------------
// upst_cell
// One buffer of the chain: tag and ready-time storage with a fill count.
// ----------------------------------------------------------------------------
`default_nettype none
module upst_cell import upst_pkg::*; #(
  parameter int unsigned DEPTH = DEF_DEPTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cell_ctl_t         ctl_i,
  input  wire logic [CNT_W-1:0]  rd_addr_i,
  output logic      [TAG_W-1:0]  rd_tag_o,
  output logic      [TIME_W-1:0] rd_rdy_o,
  output logic      [CNT_W-1:0]  fill_o,
  output logic                   full_o
);

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [TAG_W-1:0]  tag_q [DEPTH];
  logic [TIME_W-1:0] rdy_q [DEPTH];
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [CNT_W-1:0]  waddr;
  logic              we;

  // An append goes to the tail; a compaction write goes where it is told.
  assign waddr = ctl_i.push ? fill_q : ctl_i.wr_addr;
  assign we    = ctl_i.push | ctl_i.wr_en;

  always_ff @(posedge clk_i) begin
    if (we) begin
      tag_q[waddr[IDX_W-1:0]] <= ctl_i.tag;
      rdy_q[waddr[IDX_W-1:0]] <= ctl_i.rdy;
    end
  end

  // Fill count follows appends and end-of-scan loads.
  always_comb begin
    fill_d = fill_q;
    if (ctl_i.fill_set) begin
      fill_d = ctl_i.fill_val;
    end else if (ctl_i.push) begin
      fill_d = fill_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  assign rd_tag_o = tag_q[rd_addr_i[IDX_W-1:0]];
  assign rd_rdy_o = rdy_q[rd_addr_i[IDX_W-1:0]];
  assign fill_o   = fill_q;
  assign full_o   = (fill_q >= CNT_W'(DEPTH));

endmodule
`default_nettype wire

### hdl/uop_stage_pipeline_timer.sv
// ----------------------------------------------------------------------------
// uop_stage_pipeline_timer
// Timing model of a five-stage functional unit built as a chain of buffers.
// ----------------------------------------------------------------------------
// An insert is answered by one result transfer, loaded into the output
// register as the insert is taken. A tick walks the buffers one entry per
// cycle, save where the result port stalls the retirement scan: first the
// write buffer for retirement, then the execute, read, decode and issue
// buffers. The single entry read port of each buffer sets that pace.
`default_nettype none
module uop_stage_pipeline_timer import upst_pkg::*; #(
  parameter int unsigned ISSUE_DEPTH  = DEF_DEPTH,
  parameter int unsigned DECODE_DEPTH = DEF_DEPTH,
  parameter int unsigned READ_DEPTH   = DEF_DEPTH,
  parameter int unsigned EXEC_DEPTH   = DEF_DEPTH,
  parameter int unsigned WRITE_DEPTH  = DEF_DEPTH
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [23:0]           s_axis_tdata,  // uop_tag[15:0], ready_delay[23:16]
  input  wire logic                  s_axis_tuser,  // cmd
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic      [15:0]           m_axis_tdata,  // tag_out[15:0]
  output logic      [1:0]            m_axis_tuser,  // kind[1:0]
  output logic                       m_axis_tlast,  // last
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Configuration registers.
  logic [WIDTH_W-1:0] width_q;
  logic [7:0]         lat_q [NUM_STAGES];  // entry k: latency on entering buffer k

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WIDTH_W'(1);
      for (int k = 0; k < NUM_STAGES; k++) lat_q[k] <= 8'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WIDTH:     width_q           <= cfg_data_i[WIDTH_W-1:0];
        REG_DEC_LAT:   lat_q[STG_DECODE] <= cfg_data_i;
        REG_READ_LAT:  lat_q[STG_READ]   <= cfg_data_i;
        REG_EXEC_LAT:  lat_q[STG_EXEC]   <= cfg_data_i;
        REG_WRITE_LAT: lat_q[STG_WRITE]  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Chain of buffer cells.
  cell_ctl_t         ctl    [NUM_STAGES];
  logic [TAG_W-1:0]  rd_tag [NUM_STAGES];
  logic [TIME_W-1:0] rd_rdy [NUM_STAGES];
  logic [CNT_W-1:0]  fill   [NUM_STAGES];
  logic              full   [NUM_STAGES];
  logic [CNT_W-1:0]  idx_q, idx_d;

  localparam int unsigned DEPTHS [NUM_STAGES] =
    '{ISSUE_DEPTH, DECODE_DEPTH, READ_DEPTH, EXEC_DEPTH, WRITE_DEPTH};

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_cell
    upst_cell #(.DEPTH(DEPTHS[g])) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl[g]),
      .rd_addr_i (idx_q),
      .rd_tag_o  (rd_tag[g]),
      .rd_rdy_o  (rd_rdy[g]),
      .fill_o    (fill[g]),
      .full_o    (full[g])
    );
  end

  // Sequencer state.
  state_e            state_q, state_d;
  logic [2:0]        src_q, src_d;
  logic [CNT_W-1:0]  keep_q, keep_d;
  logic [RET_W-1:0]  cnt_q, cnt_d;
  logic              pend_v_q, pend_v_d;
  logic [TAG_W-1:0]  pend_tag_q, pend_tag_d;
  logic [TIME_W-1:0] cycle_q, cycle_d;

  // Output register.
  logic              out_v_q;
  logic [TAG_W-1:0]  out_tag_q;
  logic [KIND_W-1:0] out_kind_q;
  logic              out_last_q;
  logic              out_free, out_load, out_last;
  logic [TAG_W-1:0]  out_tag;
  logic [KIND_W-1:0] out_kind;

  logic [2:0]        dst;
  logic              ent_ready, in_width;

  assign out_free = !out_v_q || m_axis_tready;
  assign dst      = src_q + 3'd1;

  // Current entry of the source buffer.
  assign ent_ready = (cycle_q >= rd_rdy[src_q]);
  assign in_width  = ({1'b0, idx_q} + 8'd1) <= {4'd0, width_q};

  always_comb begin
    state_d    = state_q;
    src_d      = src_q;
    idx_d      = idx_q;
    keep_d     = keep_q;
    cnt_d      = cnt_q;
    pend_v_d   = pend_v_q;
    pend_tag_d = pend_tag_q;
    cycle_d    = cycle_q;
    out_load   = 1'b0;
    out_kind   = KIND_IDLE;
    out_tag    = '0;
    out_last   = 1'b0;
    s_axis_tready = 1'b0;
    for (int k = 0; k < NUM_STAGES; k++) ctl[k] = '0;

    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = out_free;
        if (s_axis_tvalid && out_free) begin
          if (s_axis_tuser == CMD_INSERT) begin
            out_load = 1'b1;
            out_tag  = s_axis_tdata[15:0];
            out_last = 1'b1;
            out_kind = full[STG_ISSUE] ? KIND_REJECT : KIND_ACCEPT;
            if (!full[STG_ISSUE]) begin
              ctl[STG_ISSUE].push = 1'b1;
              ctl[STG_ISSUE].tag  = s_axis_tdata[15:0];
              ctl[STG_ISSUE].rdy  = cycle_q + TIME_W'(s_axis_tdata[23:16]);
            end
          end else begin
            state_d  = ST_RETIRE;
            src_d    = STG_WRITE;
            idx_d    = '0;
            keep_d   = '0;
            cnt_d    = '0;
            pend_v_d = 1'b0;
          end
        end
      end

      // Retire ready write entries; the newest retirement waits in a pending
      // register so that the last one can carry the end mark.
      ST_RETIRE: begin
        if (idx_q == fill[STG_WRITE]) begin
          if (out_free) begin
            out_load = 1'b1;
            out_last = 1'b1;
            out_kind = pend_v_q ? KIND_RETIRE : KIND_IDLE;
            out_tag  = pend_v_q ? pend_tag_q : '0;
            ctl[STG_WRITE].fill_set = 1'b1;
            ctl[STG_WRITE].fill_val = keep_q;
            state_d = ST_MOVE;
            src_d   = STG_EXEC;
            idx_d   = '0;
            keep_d  = '0;
          end
        end else if (ent_ready && (cnt_q < RET_W'(MAX_RET))) begin
          if (!pend_v_q || out_free) begin
            if (pend_v_q) begin
              out_load = 1'b1;
              out_kind = KIND_RETIRE;
              out_tag  = pend_tag_q;
            end
            pend_v_d   = 1'b1;
            pend_tag_d = rd_tag[STG_WRITE];
            cnt_d      = cnt_q + RET_W'(1);
            idx_d      = idx_q + CNT_W'(1);
          end
        end else begin
          ctl[STG_WRITE].wr_en   = 1'b1;
          ctl[STG_WRITE].wr_addr = keep_q;
          ctl[STG_WRITE].tag     = rd_tag[STG_WRITE];
          ctl[STG_WRITE].rdy     = rd_rdy[STG_WRITE];
          keep_d = keep_q + CNT_W'(1);
          idx_d  = idx_q + CNT_W'(1);
        end
      end

      // Move ready entries within the width from the source buffer into its successor while it has room.
      ST_MOVE: begin
        if (idx_q == fill[src_q]) begin
          ctl[src_q].fill_set = 1'b1;
          ctl[src_q].fill_val = keep_q;
          idx_d  = '0;
          keep_d = '0;
          if (src_q == STG_ISSUE) begin
            cycle_d = cycle_q + TIME_W'(1);
            state_d = ST_IDLE;
          end else begin
            src_d = src_q - 3'd1;
          end
        end else if (ent_ready && in_width && !full[dst]) begin
          ctl[dst].push = 1'b1;
          ctl[dst].tag  = rd_tag[src_q];
          ctl[dst].rdy  = cycle_q + TIME_W'(lat_q[dst]);
          idx_d = idx_q + CNT_W'(1);
        end else begin
          ctl[src_q].wr_en   = 1'b1;
          ctl[src_q].wr_addr = keep_q;
          ctl[src_q].tag     = rd_tag[src_q];
          ctl[src_q].rdy     = rd_rdy[src_q];
          keep_d = keep_q + CNT_W'(1);
          idx_d  = idx_q + CNT_W'(1);
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      src_q    <= STG_WRITE;
      idx_q    <= '0;
      keep_q   <= '0;
      cnt_q    <= '0;
      pend_v_q <= 1'b0;
      cycle_q  <= '0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      src_q    <= src_d;
      idx_q    <= idx_d;
      keep_q   <= keep_d;
      cnt_q    <= cnt_d;
      pend_v_q <= pend_v_d;
      cycle_q  <= cycle_d;
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Result payload and pending tag.
  always_ff @(posedge clk_i) begin
    pend_tag_q <= pend_tag_d;
    if (out_load) begin
      out_tag_q  <= out_tag;
      out_kind_q <= out_kind;
      out_last_q <= out_last;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_tag_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

endmodule
`default_nettype wire

### hdl/upst_checker.sv
// ----------------------------------------------------------------------------
// upst_checker
// Port-level checks of the micro-op stage pipeline timer.
// ----------------------------------------------------------------------------
`default_nettype none
module upst_checker import upst_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);

  // A stalled result stays offered.
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Only retirements can be followed by more results of the same transfer.
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != KIND_RETIRE) |-> m_axis_tlast)
    else $error("single result without end mark");

  // An empty tick reports a zero tag.
  a_idle_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_IDLE) |-> (m_axis_tdata == 16'd0))
    else $error("empty tick with nonzero tag");

endmodule

bind uop_stage_pipeline_timer upst_checker u_upst_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

### test/uop_stage_pipeline_timer_tb.sv
// ----------------------------------------------------------------------------
// uop_stage_pipeline_timer_tb
// Self-checking testbench of the micro-op stage pipeline timer.
// ----------------------------------------------------------------------------
// A scoreboard keeps its own copy of the five buffers, the cycle count and the
// registers. It predicts the result transfers of every accepted command and
// compares each result transfer against the oldest prediction. A directed
// part fills and floods the chain and tries a zero width. Random phases with
// fresh register settings follow, all but the last with random idling on both sides.
`timescale 1ns / 1ps
`default_nettype none
module uop_stage_pipeline_timer_tb;
  import upst_pkg::*;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [TAG_W-1:0]  tag;
    logic              last;
  } timer_result_t;

  class timer_scoreboard;
    logic [TAG_W-1:0]  buf_tag [NUM_STAGES][DEF_DEPTH];
    logic [TIME_W-1:0] buf_rdy [NUM_STAGES][DEF_DEPTH];
    int                buf_fill[NUM_STAGES];
    logic [TIME_W-1:0] cycle_now;
    logic [3:0]        width;
    logic [7:0]        latency[NUM_STAGES];
    timer_result_t     expected_results[$];
    int                mismatches;

    function new();
      cycle_now  = '0;
      width      = 4'd1;
      mismatches = 0;
      for (int s = 0; s < NUM_STAGES; s++) begin
        buf_fill[s] = 0;
        latency[s]  = 8'd1;
      end
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_WIDTH:     width = data[3:0];
        REG_DEC_LAT:   latency[STG_DECODE] = data;
        REG_READ_LAT:  latency[STG_READ] = data;
        REG_EXEC_LAT:  latency[STG_EXEC] = data;
        REG_WRITE_LAT: latency[STG_WRITE] = data;
        default: ;
      endcase
    endfunction

    function void push_result(logic [KIND_W-1:0] kind, logic [TAG_W-1:0] tag, logic last);
      timer_result_t r;
      r.kind = kind;
      r.tag  = tag;
      r.last = last;
      expected_results.push_back(r);
    endfunction

    // Move ready entries from buffer src into the next one, compacting src.
    function void advance_stage(int src);
      int keep;
      keep = 0;
      for (int i = 0; i < buf_fill[src]; i++) begin
        if (cycle_now >= buf_rdy[src][i] && (i + 1) <= width &&
            buf_fill[src+1] < DEF_DEPTH) begin
          buf_tag[src+1][buf_fill[src+1]] = buf_tag[src][i];
          buf_rdy[src+1][buf_fill[src+1]] = cycle_now + latency[src+1];
          buf_fill[src+1]++;
        end else begin
          buf_tag[src][keep] = buf_tag[src][i];
          buf_rdy[src][keep] = buf_rdy[src][i];
          keep++;
        end
      end
      buf_fill[src] = keep;
    endfunction

    function void note_command(logic cmd, logic [TAG_W-1:0] tag, logic [DLY_W-1:0] dly);
      int keep;
      int retired;
      logic [TAG_W-1:0] ret_tag[$];
      if (cmd == CMD_INSERT) begin
        if (buf_fill[STG_ISSUE] < DEF_DEPTH) begin
          buf_tag[STG_ISSUE][buf_fill[STG_ISSUE]] = tag;
          buf_rdy[STG_ISSUE][buf_fill[STG_ISSUE]] = cycle_now + dly;
          buf_fill[STG_ISSUE]++;
          push_result(KIND_ACCEPT, tag, 1'b1);
        end else begin
          push_result(KIND_REJECT, tag, 1'b1);
        end
        return;
      end
      // Retire ready write entries, at most MAX_RET per tick.
      keep    = 0;
      retired = 0;
      for (int i = 0; i < buf_fill[STG_WRITE]; i++) begin
        if (cycle_now >= buf_rdy[STG_WRITE][i] && retired < MAX_RET) begin
          ret_tag.push_back(buf_tag[STG_WRITE][i]);
          retired++;
        end else begin
          buf_tag[STG_WRITE][keep] = buf_tag[STG_WRITE][i];
          buf_rdy[STG_WRITE][keep] = buf_rdy[STG_WRITE][i];
          keep++;
        end
      end
      buf_fill[STG_WRITE] = keep;
      for (int s = NUM_STAGES - 2; s >= 0; s--) advance_stage(s);
      cycle_now++;
      if (retired == 0) push_result(KIND_IDLE, '0, 1'b1);
      foreach (ret_tag[i]) push_result(KIND_RETIRE, ret_tag[i], i == retired - 1);
    endfunction

    function void check_result(logic [KIND_W-1:0] kind, logic [TAG_W-1:0] tag, logic last);
      timer_result_t e;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result transfer: kind=%0d tag=%h last=%b", kind, tag, last);
        return;
      end
      e = expected_results.pop_front();
      if (e.kind !== kind || e.tag !== tag || e.last !== last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected kind=%0d tag=%h last=%b, got kind=%0d tag=%h last=%b",
                   e.kind, e.tag, e.last, kind, tag, last);
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [23:0]           s_axis_tdata;  // uop_tag[15:0], ready_delay[23:16]
  logic                  s_axis_tuser;  // cmd
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [15:0]           m_axis_tdata;  // tag_out[15:0]
  logic [1:0]            m_axis_tuser;  // kind[1:0]
  logic                  m_axis_tlast;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  timer_scoreboard sb;
  bit  tx_idling;
  bit  rx_idling;
  int  rx_stall_left;
  int  cycles = 0;

  uop_stage_pipeline_timer dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Run limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 500000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: check each transfer, then stall in random bursts while idling is on.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_stall_left <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
      if (rx_stall_left > 0) begin
        rx_stall_left <= rx_stall_left - 1;
        m_axis_tready <= 1'b0;
      end else if (rx_idling && $urandom_range(0, 5) == 0) begin
        rx_stall_left <= $urandom_range(0, 10);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Send one command, with an optional random gap, and note it once accepted.
  task automatic send_command(logic cmd, logic [TAG_W-1:0] tag, logic [DLY_W-1:0] dly);
    if (tx_idling && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {dly, tag};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_command(cmd, tag, dly);
  endtask

  // Wait for every expected result, then for the tail of a tick scan.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_register(idx, data);
  endtask

  task automatic random_command();
    logic [DLY_W-1:0] dly;
    dly = ($urandom_range(0, 4) == 0) ? DLY_W'($urandom) : DLY_W'($urandom_range(0, 6));
    send_command($urandom_range(0, 99) < 45 ? CMD_INSERT : CMD_TICK, TAG_W'($urandom), dly);
  endtask

  initial begin
    sb            = new();
    tx_idling     = 1'b0;
    rx_idling     = 1'b0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= '0;
    cfg_data_i    <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: full width, no latency, flood all stages and retire eight at once.
    write_register(REG_WIDTH, 8'd8);
    write_register(REG_DEC_LAT, 8'd0);
    write_register(REG_READ_LAT, 8'd0);
    write_register(REG_EXEC_LAT, 8'd0);
    write_register(REG_WRITE_LAT, 8'd0);
    write_register(3'd5, 8'hFF);  // out of range, ignored
    write_register(3'd7, 8'h00);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    send_command(CMD_INSERT, 16'hFFFF, 8'd0);
    send_command(CMD_INSERT, 16'h0000, 8'd0);
    for (int i = 0; i < 6; i++) send_command(CMD_INSERT, TAG_W'(16'h1230 + i), 8'd0);
    send_command(CMD_INSERT, 16'hBEEF, 8'd0);  // issue buffer full
    for (int i = 0; i < 5; i++) send_command(CMD_TICK, 16'hFFFF, 8'hFF);
    send_command(CMD_INSERT, 16'h5A5A, 8'hFF);
    send_command(CMD_TICK, 16'h0000, 8'd0);
    drain();

    // Zero width: a masked write of 0 stops every stage.
    write_register(REG_WIDTH, 8'hF0);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    send_command(CMD_INSERT, 16'hA5A5, 8'd0);
    for (int i = 0; i < 3; i++) send_command(CMD_TICK, 16'h0000, 8'd0);
    drain();

    // Random phases, each with its own register setting.
    for (int phase = 0; phase < 4; phase++) begin
      tx_idling = (phase != 3);
      rx_idling = (phase != 3);
      case (phase)
        0: begin
          write_register(REG_WIDTH, 8'd1);
          write_register(REG_DEC_LAT, 8'd255);
          write_register(REG_READ_LAT, 8'd0);
          write_register(REG_EXEC_LAT, 8'd255);
          write_register(REG_WRITE_LAT, 8'd0);
        end
        1: for (int r = 0; r < NUM_STAGES; r++)
          write_register(CFG_IDX_W'(r), CFG_DATA_W'($urandom));
        default: begin
          write_register(REG_WIDTH, CFG_DATA_W'($urandom_range(2, 15)));
          write_register(REG_DEC_LAT, CFG_DATA_W'($urandom_range(0, 3)));
          write_register(REG_READ_LAT, CFG_DATA_W'($urandom_range(0, 3)));
          write_register(REG_EXEC_LAT, CFG_DATA_W'($urandom_range(0, 3)));
          write_register(REG_WRITE_LAT, CFG_DATA_W'($urandom_range(0, 3)));
        end
      endcase
      cfg_we_i <= 1'b0;
      @(posedge clk_i);
      for (int n = 0; n < 75; n++) begin
        random_command();
        // Sender holds off once until every expected result is back.
        if (phase == 1 && n == 40) drain();
      end
      drain();
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire
